>>> hw/rtl/command_frame_deframer_unit_defines.svh
// assertion macros for the command frame deframer
`ifndef COMMAND_FRAME_DEFRAMER_UNIT_DEFINES_SVH
`define COMMAND_FRAME_DEFRAMER_UNIT_DEFINES_SVH

// same-cycle implication, held off during reset
`define CFD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define CFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/cfd_pkg.sv
// shared types, constants and crc function for the command frame deframer
package cfd_pkg;

  localparam int MAX_FRAME    = 256;
  localparam int HEADER_BYTES = 7;
  localparam int MIN_FRAME    = HEADER_BYTES + 9;
  localparam int POS_W        = $clog2(MAX_FRAME + 1);
  localparam int SUM_W        = 17;
  localparam int QDEPTH       = 4;
  localparam int QPTR_W       = $clog2(QDEPTH);
  localparam int QLVL_W       = $clog2(QDEPTH + 1);
  localparam int ADDR_W       = 5;
  localparam int DATA_W       = 32;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [7:0]  LIMIT_RESET = 8'd200;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_SHORT = 3'd1,
    ST_BAD_START = 3'd2,
    ST_BAD_END   = 3'd3,
    ST_BAD_CRC   = 3'd4,
    ST_TOO_LONG  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    REG_START_FIRST   = 3'd0,
    REG_START_SECOND  = 3'd1,
    REG_END_FIRST     = 3'd2,
    REG_END_SECOND    = 3'd3,
    REG_PAYLOAD_LIMIT = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] start_first;
    logic [7:0] start_second;
    logic [7:0] end_first;
    logic [7:0] end_second;
    logic [7:0] payload_limit;
  } cfg_t;

  // one result word between front and back; data holds the payload byte
  // or, on a status word, the accepted payload count
  typedef struct packed {
    logic        is_status;
    logic [7:0]  data;
    status_t     status;
    logic [7:0]  kind;
    logic [7:0]  cmd;
    logic [15:0] seq;
  } entry_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QLVL_W-1:0] level;
  } q_stat_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  payload_data;
    logic [2:0]  frame_status;
    logic [7:0]  packet_kind;
    logic [7:0]  command_code;
    logic [15:0] sequence_number;
    logic [7:0]  payload_count;
    logic        last_of_frame;
  } out_word_t;

  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> hw/rtl/cfd_front.sv
// front end: byte tracking, crc, field capture and frame classification
module cfd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  logic [7:0]        byte_in,
  input  logic              last_in,
  input  cfd_pkg::cfg_t     cfg,
  output logic              res_valid,
  output cfd_pkg::entry_t   res
);

  logic [cfd_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]               crc_r, crc_nxt;
  logic [7:0]                td_r [4];
  logic [7:0]                td_nxt [4];
  logic [7:0]                fb0_r, fb0_nxt, fb1_r, fb1_nxt;
  logic [7:0]                kind_r, kind_nxt, cmd_r, cmd_nxt;
  logic [15:0]               seq_r, seq_nxt, len_r, len_nxt;
  logic                      ovf_r, ovf_nxt;

  logic                      ovf;
  logic                      len_ok;
  logic [cfd_pkg::SUM_W-1:0] len_end;
  logic                      fits;
  logic                      emit;
  cfd_pkg::status_t          status;

  localparam logic [cfd_pkg::POS_W-1:0] P_MAX  = cfd_pkg::POS_W'(cfd_pkg::MAX_FRAME);
  localparam logic [cfd_pkg::POS_W-1:0] P_HDR  = cfd_pkg::POS_W'(cfd_pkg::HEADER_BYTES);
  localparam logic [cfd_pkg::POS_W-1:0] P_PAY  = cfd_pkg::POS_W'(cfd_pkg::HEADER_BYTES + 8);
  localparam logic [cfd_pkg::POS_W-1:0] P_SHRT = cfd_pkg::POS_W'(cfd_pkg::MIN_FRAME - 1);

  always_comb begin
    ovf     = ovf_r | (pos_r >= P_MAX);
    len_ok  = (len_r != 16'd0) && (len_r <= {8'h00, cfg.payload_limit});
    len_end = {1'b0, len_r} + cfd_pkg::SUM_W'(cfd_pkg::HEADER_BYTES + 8);
    fits    = len_end <= cfd_pkg::SUM_W'(pos_r);
    emit    = !ovf && len_ok && (pos_r >= P_PAY) && (cfd_pkg::SUM_W'(pos_r) < len_end);
    crc_nxt = (!ovf && pos_r >= cfd_pkg::POS_W'(4)) ? cfd_pkg::crc_fold(crc_r, td_r[3]) : crc_r;

    if (ovf) begin
      status = cfd_pkg::ST_TOO_LONG;
    end else if (pos_r < P_SHRT) begin
      status = cfd_pkg::ST_TOO_SHORT;
    end else if (fb0_r != cfg.start_first || fb1_r != cfg.start_second) begin
      status = cfd_pkg::ST_BAD_START;
    end else if (td_r[0] != cfg.end_first || byte_in != cfg.end_second) begin
      status = cfd_pkg::ST_BAD_END;
    end else if (crc_nxt != {td_r[2], td_r[1]}) begin
      status = cfd_pkg::ST_BAD_CRC;
    end else begin
      status = cfd_pkg::ST_OK;
    end

    res_valid     = acc && (last_in || emit);
    res.is_status = last_in;
    res.data      = last_in ? ((len_ok && fits) ? len_r[7:0] : 8'h00) : td_r[2];
    res.status    = status;
    res.kind      = kind_r;
    res.cmd       = cmd_r;
    res.seq       = seq_r;

    pos_nxt  = pos_r;
    fb0_nxt  = fb0_r;
    fb1_nxt  = fb1_r;
    kind_nxt = kind_r;
    cmd_nxt  = cmd_r;
    seq_nxt  = seq_r;
    len_nxt  = len_r;
    ovf_nxt  = ovf;
    for (int i = 0; i < 4; i++) begin
      td_nxt[i] = td_r[i];
    end

    if (!ovf) begin
      if (pos_r == cfd_pkg::POS_W'(0)) fb0_nxt = byte_in;
      if (pos_r == cfd_pkg::POS_W'(1)) fb1_nxt = byte_in;
      if (pos_r == cfd_pkg::POS_W'(2)) kind_nxt = byte_in;
      if (pos_r == P_HDR) cmd_nxt = byte_in;
      if (pos_r == P_HDR + cfd_pkg::POS_W'(1)) seq_nxt[15:8] = byte_in;
      if (pos_r == P_HDR + cfd_pkg::POS_W'(2)) seq_nxt[7:0] = byte_in;
      if (pos_r == P_HDR + cfd_pkg::POS_W'(3)) len_nxt[15:8] = byte_in;
      if (pos_r == P_HDR + cfd_pkg::POS_W'(4)) len_nxt[7:0] = byte_in;
      td_nxt[3] = td_r[2];
      td_nxt[2] = td_r[1];
      td_nxt[1] = td_r[0];
      td_nxt[0] = byte_in;
    end
    if (pos_r < P_MAX) pos_nxt = pos_r + cfd_pkg::POS_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (acc && last_in)) begin
      pos_r  <= '0;
      crc_r  <= cfd_pkg::CRC_INIT;
      fb0_r  <= '0;
      fb1_r  <= '0;
      kind_r <= '0;
      cmd_r  <= '0;
      seq_r  <= '0;
      len_r  <= '0;
      ovf_r  <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        td_r[i] <= '0;
      end
    end else if (acc) begin
      pos_r  <= pos_nxt;
      crc_r  <= crc_nxt;
      fb0_r  <= fb0_nxt;
      fb1_r  <= fb1_nxt;
      kind_r <= kind_nxt;
      cmd_r  <= cmd_nxt;
      seq_r  <= seq_nxt;
      len_r  <= len_nxt;
      ovf_r  <= ovf_nxt;
      for (int i = 0; i < 4; i++) begin
        td_r[i] <= td_nxt[i];
      end
    end
  end

endmodule

>>> hw/rtl/cfd_queue.sv
// short result word queue between front and back
module cfd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_i,
  input  cfd_pkg::entry_t   din,
  input  logic              pop_i,
  output cfd_pkg::entry_t   dout,
  output cfd_pkg::q_stat_t  stat
);

  cfd_pkg::entry_t              mem_r [cfd_pkg::QDEPTH];
  logic [cfd_pkg::QPTR_W-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [cfd_pkg::QLVL_W-1:0]   lvl_r, lvl_nxt;
  logic                         do_push, do_pop;

  always_comb begin
    stat.full  = lvl_r == cfd_pkg::QLVL_W'(cfd_pkg::QDEPTH);
    stat.empty = lvl_r == '0;
    stat.level = lvl_r;
    do_push    = push_i && !stat.full;
    do_pop     = pop_i && !stat.empty;
    wr_nxt     = do_push ? wr_r + cfd_pkg::QPTR_W'(1) : wr_r;
    rd_nxt     = do_pop ? rd_r + cfd_pkg::QPTR_W'(1) : rd_r;
    lvl_nxt    = lvl_r + cfd_pkg::QLVL_W'(do_push) - cfd_pkg::QLVL_W'(do_pop);
    dout       = mem_r[rd_r];
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      lvl_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      lvl_r <= lvl_nxt;
    end
  end

endmodule

>>> hw/rtl/cfd_back.sv
// back end: result word formatting and output register
module cfd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  cfd_pkg::entry_t     q_head,
  output logic                q_pop,
  input  logic                pop,
  output logic                empty,
  output cfd_pkg::out_word_t  word
);

  logic                valid_r, valid_nxt;
  cfd_pkg::out_word_t  word_r, word_nxt;
  logic                ok;

  always_comb begin
    q_pop     = !q_empty && (!valid_r || pop);
    valid_nxt = q_pop || (valid_r && !pop);
    ok        = q_head.is_status && (q_head.status == cfd_pkg::ST_OK);

    word_nxt.result_kind     = q_head.is_status;
    word_nxt.payload_data    = q_head.is_status ? 8'h00 : q_head.data;
    word_nxt.frame_status    = q_head.is_status ? q_head.status : cfd_pkg::ST_OK;
    word_nxt.packet_kind     = ok ? q_head.kind : 8'h00;
    word_nxt.command_code    = ok ? q_head.cmd : 8'h00;
    word_nxt.sequence_number = ok ? q_head.seq : 16'h0000;
    word_nxt.payload_count   = ok ? q_head.data : 8'h00;
    word_nxt.last_of_frame   = q_head.is_status;

    empty = !valid_r;
    word  = word_r;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      word_r <= word_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule

>>> hw/rtl/command_frame_deframer_unit.sv
// top level of the command frame deframer
//
// Input side is a queue: drive in_frame_byte and in_frame_end with push; a
// byte is taken at a clock edge where push is high and full is low. Mark the
// final byte of each frame with in_frame_end.
// Result side is a queue: while empty is low the oldest word is on the out_
// ports and pop takes it. Payload bytes come out as words with result_kind 0;
// the final byte of a frame yields one status word with result_kind 1.
// While full is low one byte per cycle is taken and the crc folds one byte
// per cycle. A result word enters the queue at the edge its byte is taken and
// moves from the queue into the output register that drives the out_ ports.
// When pop stays low, a four word queue and the output register fill, then
// full rises and holds off further bytes until words are taken.
// Registers are written over the APB port at byte addresses 0, 4, 8, 12, 16.
// Synchronous reset clears the frame state, empties the queue and loads the
// register reset values.
module command_frame_deframer_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  output logic                        full,
  input  logic [7:0]                  in_frame_byte,
  input  logic                        in_frame_end,
  output logic                        empty,
  input  logic                        pop,
  output logic                        out_result_kind,
  output logic [7:0]                  out_payload_data,
  output logic [2:0]                  out_frame_status,
  output logic [7:0]                  out_packet_kind,
  output logic [7:0]                  out_command_code,
  output logic [15:0]                 out_sequence_number,
  output logic [7:0]                  out_payload_count,
  output logic                        out_last_of_frame,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cfd_pkg::ADDR_W-1:0]  paddr,
  input  logic [cfd_pkg::DATA_W-1:0]  pwdata,
  output logic [cfd_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  `include "command_frame_deframer_unit_defines.svh"

  cfd_pkg::cfg_t       cfg_r, cfg_nxt;
  cfd_pkg::reg_idx_t   reg_idx;
  logic                cfg_wr;
  logic                in_acc;
  logic                res_valid;
  cfd_pkg::entry_t     res;
  cfd_pkg::entry_t     q_head;
  cfd_pkg::q_stat_t    q_stat;
  logic                q_pop;
  cfd_pkg::out_word_t  word;

  always_comb begin
    pready  = 1'b1;
    cfg_wr  = psel && penable && pwrite && pready;
    reg_idx = cfd_pkg::reg_idx_t'(paddr[4:2]);
    cfg_nxt = cfg_r;
    prdata  = '0;
    unique case (reg_idx)
      cfd_pkg::REG_START_FIRST: begin
        prdata[7:0] = cfg_r.start_first;
        if (cfg_wr) cfg_nxt.start_first = pwdata[7:0];
      end
      cfd_pkg::REG_START_SECOND: begin
        prdata[7:0] = cfg_r.start_second;
        if (cfg_wr) cfg_nxt.start_second = pwdata[7:0];
      end
      cfd_pkg::REG_END_FIRST: begin
        prdata[7:0] = cfg_r.end_first;
        if (cfg_wr) cfg_nxt.end_first = pwdata[7:0];
      end
      cfd_pkg::REG_END_SECOND: begin
        prdata[7:0] = cfg_r.end_second;
        if (cfg_wr) cfg_nxt.end_second = pwdata[7:0];
      end
      cfd_pkg::REG_PAYLOAD_LIMIT: begin
        prdata[7:0] = cfg_r.payload_limit;
        if (cfg_wr) cfg_nxt.payload_limit = pwdata[7:0];
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_first   <= 8'h00;
      cfg_r.start_second  <= 8'h00;
      cfg_r.end_first     <= 8'h00;
      cfg_r.end_second    <= 8'h00;
      cfg_r.payload_limit <= cfd_pkg::LIMIT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign full   = q_stat.full;
  assign in_acc = push && !full;

  cfd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (in_acc),
    .byte_in   (in_frame_byte),
    .last_in   (in_frame_end),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res)
  );

  cfd_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (res_valid),
    .din    (res),
    .pop_i  (q_pop),
    .dout   (q_head),
    .stat   (q_stat)
  );

  cfd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_stat.empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .word    (word)
  );

  assign out_result_kind     = word.result_kind;
  assign out_payload_data    = word.payload_data;
  assign out_frame_status    = word.frame_status;
  assign out_packet_kind     = word.packet_kind;
  assign out_command_code    = word.command_code;
  assign out_sequence_number = word.sequence_number;
  assign out_payload_count   = word.payload_count;
  assign out_last_of_frame   = word.last_of_frame;

  `CFD_ASSERT_IMPL(a_status_closes, !empty && out_result_kind,
    out_last_of_frame && out_payload_data == 8'h00, "status word without frame close")
  `CFD_ASSERT_IMPL(a_payload_clean, !empty && !out_result_kind,
    !out_last_of_frame && out_frame_status == cfd_pkg::ST_OK && out_payload_count == 8'h00,
    "payload word carries status fields")
  `CFD_ASSERT_IMPL(a_error_clean,
    !empty && out_result_kind && out_frame_status != cfd_pkg::ST_OK,
    out_packet_kind == 8'h00 && out_command_code == 8'h00 && out_payload_count == 8'h00,
    "failed frame reports captured fields")
  `CFD_ASSERT_NEXT(a_full_holds_word, full, !empty, "output register empty after full queue")

endmodule
